FILE: rtl/core/sorted_two_list_merge_unit_macros.svh
// ---------------------------------------------------------------------------
// sorted_two_list_merge_unit_macros.svh
// Assertion macros for the merge unit checker.
// They use the clock and reset signals of the scope where they are placed.
// ---------------------------------------------------------------------------
`ifndef SORTED_TWO_LIST_MERGE_UNIT_MACROS_SVH
`define SORTED_TWO_LIST_MERGE_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define SMERGE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check the consequent in the cycle after the antecedent
`define SMERGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/smerge_pkg.sv
// ---------------------------------------------------------------------------
// smerge_pkg
// Shared constants and control/status types for the two-list merge unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package smerge_pkg;

   // Buffer depth default and field widths
   localparam int SEQ_DEPTH_DEF = 32;
   localparam int DATA_W        = 32;
   localparam int MODE_W        = 2;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_APPEND_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MERGE    = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic append_a;
      logic append_b;
      logic pick;
      logic finish;
   } smerge_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic total_zero;
      logic last_pick;
      logic out_free;
   } smerge_stat_type;

endpackage

FILE: rtl/core/smerge_ram.sv
// ---------------------------------------------------------------------------
// smerge_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smerge_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/smerge_ctrl.sv
// ---------------------------------------------------------------------------
// smerge_ctrl
// Controller: takes append and merge transactions, sequences the merge.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smerge_ctrl import smerge_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  smerge_stat_type   stat,
   output smerge_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_take;

   // Take transactions only while idle
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.append_a = (req_mode == MODE_APPEND_A);
               cmd.append_b = (req_mode == MODE_APPEND_B);
               if ((req_mode == MODE_MERGE) && !stat.total_zero) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            // Advance one element whenever the output register can take it
            if (stat.out_free) begin
               cmd.pick = 1'b1;
               if (stat.last_pick) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/smerge_dp.sv
// ---------------------------------------------------------------------------
// smerge_dp
// Datapath: two sequence buffers, fill counts, read indices, head compare
// and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smerge_dp import smerge_pkg::*; #(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smerge_cmd_type           cmd,
   output smerge_stat_type          stat,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_merged_value,
   output logic                     rsp_last
);

   localparam int ADDR_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SEQ_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SEQ_DEPTH);

   logic [CNT_W-1:0]  count_a_ff, count_a_in;
   logic [CNT_W-1:0]  count_b_ff, count_b_in;
   logic [CNT_W-1:0]  ia_ff, ia_in;
   logic [CNT_W-1:0]  ib_ff, ib_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              wr_a, wr_b;
   logic [DATA_W-1:0] a_head, b_head;
   logic              a_avail, b_avail, a_take;
   logic [CNT_W:0]    done_next, total;

   // Sequence buffers; read address follows the next index
   smerge_ram #(.WIDTH(DATA_W), .DEPTH(SEQ_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (ia_in[ADDR_W-1:0]),
      .rd_data (a_head)
   );

   smerge_ram #(.WIDTH(DATA_W), .DEPTH(SEQ_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (ib_in[ADDR_W-1:0]),
      .rd_data (b_head)
   );

   // Drop appends to a full buffer
   assign wr_a = cmd.append_a && (count_a_ff != FULL_COUNT);
   assign wr_b = cmd.append_b && (count_b_ff != FULL_COUNT);

   // Head compare: B wins on equal values
   assign a_avail = (ia_ff < count_a_ff);
   assign b_avail = (ib_ff < count_b_ff);
   assign a_take  = a_avail && (!b_avail || ($signed(a_head) < $signed(b_head)));

   // Final element when this pick brings the emitted count to the total
   assign done_next = {1'b0, ia_ff} + {1'b0, ib_ff} + (CNT_W+1)'(1);
   assign total     = {1'b0, count_a_ff} + {1'b0, count_b_ff};

   assign stat.total_zero = (total == '0);
   assign stat.last_pick  = (done_next == total);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // Counts and indices
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      priority if (cmd.finish) begin
         count_a_in = '0;
         count_b_in = '0;
         ia_in      = '0;
         ib_in      = '0;
      end else if (cmd.pick) begin
         if (a_take) begin
            ia_in = ia_ff + CNT_W'(1);
         end else begin
            ib_in = ib_ff + CNT_W'(1);
         end
      end else begin
         if (wr_a) begin
            count_a_in = count_a_ff + CNT_W'(1);
         end
         if (wr_b) begin
            count_b_in = count_b_ff + CNT_W'(1);
         end
      end
   end

   // Result register: load on pick, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.pick) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = a_take ? a_head : b_head;
         rsp_last_in  = stat.last_pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = $signed(rsp_value_ff);
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: rtl/core/sorted_two_list_merge_unit.sv
// Appends: one transaction per cycle while idle, no result; the buffer write lands at the
// clock edge. Merge: the transaction moves the controller to ST_MERGE, whose first pick
// registers the first element, then one element per cycle while rsp_stall is low; the
// unit stays busy until its final pick. Merging two empty buffers never makes it busy.
// The rate is set by the head-compare loop feeding the registered RAM read addresses.
// Reset (synchronous) empties both buffers and drops any pending result; no clearing pass.
// ---------------------------------------------------------------------------
// sorted_two_list_merge_unit
// Loads two ascending sequences and emits their ascending merge.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_two_list_merge_unit import smerge_pkg::*; #(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_merged_value,
   output logic                     rsp_last
);

   smerge_cmd_type  cmd;
   smerge_stat_type stat;

   // Sequencing
   smerge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, compare and result register
   smerge_dp #(.SEQ_DEPTH(SEQ_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: rtl/core/smerge_chk.sv
// ---------------------------------------------------------------------------
// smerge_chk
// Port-level checks on the merge unit, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_two_list_merge_unit_macros.svh"

module smerge_chk import smerge_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [MODE_W-1:0]        req_mode,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_merged_value,
   input logic                     rsp_last
);

   // A stalled result holds its payload
   `SMERGE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_merged_value) && $stable(rsp_last), "stalled result changed")

   // The unit stays busy while a non-final element is pending
   `SMERGE_ASSERT_SAME(a_busy_mid_merge, rsp_valid && !rsp_last, req_stall, "input taken in the middle of a merge")

   // After a non-final element goes out the merge runs on or its final element is up
   `SMERGE_ASSERT_NEXT(a_busy_after_elem, rsp_valid && !rsp_stall && !rsp_last, req_stall || (rsp_valid && rsp_last), "merge ended before its final element")

   // Appends and unused modes never start a result
   `SMERGE_ASSERT_NEXT(a_append_silent, req_valid && !req_stall && (req_mode != MODE_MERGE), !$rose(rsp_valid), "result after a non-merge transaction")

endmodule

bind sorted_two_list_merge_unit smerge_chk u_smerge_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_merged_value (rsp_merged_value),
   .rsp_last         (rsp_last)
);
